FILE: hdl/cps_pkg.sv
// ---------------------------------------------------------------------------
// cps_pkg
// Shared types and constants for the cycle period statistics block: sample
// and snapshot layouts, and the constant reciprocals for the ns-to-us divide.
// ---------------------------------------------------------------------------
package cps_pkg;

  localparam int PERIOD_W = 48;
  localparam int REQ_W    = 32;
  localparam int ACC_W    = 64;

  // rounding: q = (|ns| + 500) / 1000, done as ((x >> 3) / 125) in two chunks
  localparam int NS_PER_US = 1000;
  localparam int HALF_US   = NS_PER_US / 2;
  localparam int PRE_SHIFT = 3;
  localparam int DIV_REM   = NS_PER_US >> PRE_SHIFT;

  localparam int MAG_W = PERIOD_W;
  localparam int Y_W   = MAG_W - PRE_SHIFT;
  localparam int YL_W  = 24;
  localparam int YH_W  = Y_W - YL_W;
  localparam int QH_W  = 15;
  localparam int REM_W = 7;
  localparam int V_W   = REM_W + YL_W;
  localparam int Q_W   = QH_W + YL_W;
  localparam int QB_W  = 19;
  localparam int QA_W  = Q_W - QB_W;

  localparam int HI_K  = 29;
  localparam int LO_K  = 38;
  localparam int HR_W  = 23;
  localparam int LR_W  = 32;
  localparam int HP_W  = YH_W + HR_W;
  localparam int LP_W  = V_W + LR_W;

  localparam logic [HR_W-1:0] HI_RECIP =
    HR_W'(((64'd1 << HI_K) + 64'(DIV_REM) - 64'd1) / 64'(DIV_REM));
  localparam logic [LR_W-1:0] LO_RECIP =
    LR_W'(((64'd1 << LO_K) + 64'(DIV_REM) - 64'd1) / 64'(DIV_REM));

  typedef struct packed {
    logic signed [PERIOD_W-1:0] cyc_period;
    logic signed [PERIOD_W-1:0] wake_late;
    logic                       overrun_flag;
    logic                       clamp_flag;
    logic [REQ_W-1:0]           win_req;
  } sample_t;

  typedef struct packed {
    sample_t        smp;
    logic           neg;
    logic [Q_W-1:0] mag_us;
  } round_t;

  typedef struct packed {
    sample_t                 smp;
    logic [ACC_W-1:0]        square;
    logic signed [ACC_W-1:0] delta_us;
  } sq_t;

  typedef struct packed {
    logic [ACC_W-1:0]           sample_count;
    logic signed [ACC_W-1:0]    period_sum_us;
    logic [ACC_W-1:0]           period_square_sum;
    logic [ACC_W-1:0]           overrun_count;
    logic [ACC_W-1:0]           clamp_count;
    logic signed [PERIOD_W-1:0] window_min_period;
    logic signed [PERIOD_W-1:0] window_max_period;
    logic signed [PERIOD_W-1:0] window_max_lateness;
    logic [REQ_W-1:0]           window_number;
  } stats_t;

endpackage

FILE: hdl/cps_in_if.sv
// ---------------------------------------------------------------------------
// cps_in_if
// Sample channel: valid/ready handshake carrying one control-cycle sample.
// ---------------------------------------------------------------------------
interface cps_in_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] cyc_period;
  logic signed [47:0] wake_late;
  logic               overrun_flag;
  logic               clamp_flag;
  logic [31:0]        win_req;

  modport source (
    output valid, cyc_period, wake_late, overrun_flag, clamp_flag, win_req,
    input  ready
  );
  modport sink (
    input  valid, cyc_period, wake_late, overrun_flag, clamp_flag, win_req,
    output ready
  );
endinterface

FILE: hdl/cps_out_if.sv
// ---------------------------------------------------------------------------
// cps_out_if
// Snapshot channel: valid/ready handshake carrying one statistics snapshot.
// ---------------------------------------------------------------------------
interface cps_out_if;
  logic               valid;
  logic               ready;
  logic [63:0]        sample_count;
  logic signed [63:0] period_sum_us;
  logic [63:0]        period_square_sum;
  logic [63:0]        overrun_count;
  logic [63:0]        clamp_count;
  logic signed [47:0] window_min_period;
  logic signed [47:0] window_max_period;
  logic signed [47:0] window_max_lateness;
  logic [31:0]        window_number;

  modport source (
    output valid, sample_count, period_sum_us, period_square_sum, overrun_count,
           clamp_count, window_min_period, window_max_period, window_max_lateness,
           window_number,
    input  ready
  );
  modport sink (
    input  valid, sample_count, period_sum_us, period_square_sum, overrun_count,
           clamp_count, window_min_period, window_max_period, window_max_lateness,
           window_number,
    output ready
  );
endinterface

FILE: hdl/cycle_period_statistics.sv
// ---------------------------------------------------------------------------
// cycle_period_statistics
// Windowed running min/max, plus whole-run sum and sum of squares, of periods.
//
// in_chan carries one sample per beat (period, lateness, overrun and clamp
// flags, window request number); out_chan returns one snapshot per sample.
// A changed request number, or a zero sample count, opens a new window.
// Pipeline: input register, three rounding stages (two reciprocal multiplies
// for the divide by 1000), two squaring stages, then the statistics state,
// which doubles as the result register.
// Throughput: one sample per cycle while out_chan accepts every snapshot;
// the 64-bit accumulators update directly in the statistics state.
// Reset (synchronous, rst_n low) clears all statistics and empties the
// pipeline. When out_chan stalls, the snapshot holds, and in_chan keeps
// accepting until every pipeline stage is full, then deasserts ready.
// ---------------------------------------------------------------------------
module cycle_period_statistics (
  input logic       clk,
  input logic       rst_n,
  cps_in_if.sink    in_chan,
  cps_out_if.source out_chan
);
  import cps_pkg::*;

  sample_t in_data;
  round_t  rnd_data;
  sq_t     sq_data;
  stats_t  stats;
  logic    rnd_valid, rnd_ready;
  logic    sq_valid, sq_ready;

  assign in_data.cyc_period   = in_chan.cyc_period;
  assign in_data.wake_late    = in_chan.wake_late;
  assign in_data.overrun_flag = in_chan.overrun_flag;
  assign in_data.clamp_flag   = in_chan.clamp_flag;
  assign in_data.win_req      = in_chan.win_req;

  cps_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_data   (in_data),
    .out_valid (rnd_valid),
    .out_ready (rnd_ready),
    .out_data  (rnd_data)
  );

  cps_square u_square (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rnd_valid),
    .in_ready  (rnd_ready),
    .in_data   (rnd_data),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_data  (sq_data)
  );

  cps_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .in_data   (sq_data),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (stats)
  );

  assign out_chan.sample_count        = stats.sample_count;
  assign out_chan.period_sum_us       = stats.period_sum_us;
  assign out_chan.period_square_sum   = stats.period_square_sum;
  assign out_chan.overrun_count       = stats.overrun_count;
  assign out_chan.clamp_count         = stats.clamp_count;
  assign out_chan.window_min_period   = stats.window_min_period;
  assign out_chan.window_max_period   = stats.window_max_period;
  assign out_chan.window_max_lateness = stats.window_max_lateness;
  assign out_chan.window_number       = stats.window_number;

endmodule

FILE: hdl/cps_round.sv
// ---------------------------------------------------------------------------
// cps_round
// Four-stage pipeline rounding the period to microseconds, half away from
// zero: magnitude and high-chunk reciprocal multiply, remainder, low-chunk
// reciprocal multiply, quotient assembly.
// ---------------------------------------------------------------------------
module cps_round (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cps_pkg::sample_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cps_pkg::round_t   out_data
);
  import cps_pkg::*;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic rdy1, rdy2, rdy3, rdy4;

  sample_t s1_smp_r, s2_smp_r, s3_smp_r, s4_smp_r;
  logic    s2_neg_r, s3_neg_r, s4_neg_r;

  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  biased;
  logic [Y_W-1:0]    scaled;
  logic [HP_W-1:0]   prod_h;
  logic [HP_W-1:0]   s2_prod_r;
  logic [YH_W-1:0]   s2_yh_r;
  logic [YL_W-1:0]   s2_yl_r;

  logic [QH_W-1:0]   qh;
  logic [YH_W-1:0]   rem_full;
  logic [QH_W-1:0]   s3_qh_r, s4_qh_r;
  logic [V_W-1:0]    s3_low_r;

  logic [LP_W-1:0]   prod_l;
  logic [LP_W-1:0]   s4_prod_r;

  assign rdy4     = !s4_v_r || out_ready;
  assign rdy3     = !s3_v_r || rdy4;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
    end
  end

  // stage 1: magnitude + half, scale down by 8, high chunk times reciprocal
  assign mag    = s1_smp_r.cyc_period[PERIOD_W-1] ?
                  (~s1_smp_r.cyc_period + MAG_W'(1)) : s1_smp_r.cyc_period;
  assign biased = mag + MAG_W'(HALF_US);
  assign scaled = biased[MAG_W-1:PRE_SHIFT];
  assign prod_h = HP_W'(scaled[Y_W-1:YL_W]) * HP_W'(HI_RECIP);

  // stage 2: high quotient and remainder
  assign qh       = s2_prod_r[HP_W-1:HI_K];
  assign rem_full = s2_yh_r - YH_W'(qh) * YH_W'(DIV_REM);

  // stage 3: low chunk times reciprocal
  assign prod_l = LP_W'(s3_low_r) * LP_W'(LO_RECIP);

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      s1_smp_r <= in_data;
    end
    if (s1_v_r && rdy2) begin
      s2_smp_r  <= s1_smp_r;
      s2_neg_r  <= s1_smp_r.cyc_period[PERIOD_W-1];
      s2_yh_r   <= scaled[Y_W-1:YL_W];
      s2_yl_r   <= scaled[YL_W-1:0];
      s2_prod_r <= prod_h;
    end
    if (s2_v_r && rdy3) begin
      s3_smp_r <= s2_smp_r;
      s3_neg_r <= s2_neg_r;
      s3_qh_r  <= qh;
      s3_low_r <= {rem_full[REM_W-1:0], s2_yl_r};
    end
    if (s3_v_r && rdy4) begin
      s4_smp_r  <= s3_smp_r;
      s4_neg_r  <= s3_neg_r;
      s4_qh_r   <= s3_qh_r;
      s4_prod_r <= prod_l;
    end
  end

  assign out_valid       = s4_v_r;
  assign out_data.smp    = s4_smp_r;
  assign out_data.neg    = s4_neg_r;
  assign out_data.mag_us = {s4_qh_r, s4_prod_r[LO_K+YL_W-1:LO_K]};

endmodule

FILE: hdl/cps_square.sv
// ---------------------------------------------------------------------------
// cps_square
// Two-stage pipeline: partial products of the rounded magnitude, then the
// square modulo 2^64 and the signed microsecond increment.
// ---------------------------------------------------------------------------
module cps_square (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cps_pkg::round_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output cps_pkg::sq_t     out_data
);
  import cps_pkg::*;

  logic s5_v_r, s6_v_r;
  logic rdy5, rdy6;

  logic [QA_W-1:0]        qa;
  logic [QB_W-1:0]        qb;
  sample_t                s5_smp_r;
  logic                   s5_neg_r;
  logic [Q_W-1:0]         s5_q_r;
  logic [2*QA_W-1:0]      s5_hh_r;
  logic [QA_W+QB_W-1:0]   s5_hl_r;
  logic [2*QB_W-1:0]      s5_ll_r;

  logic [ACC_W-1:0]       square;
  logic [ACC_W-1:0]       delta;
  sq_t                    s6_r;

  assign rdy6     = !s6_v_r || out_ready;
  assign rdy5     = !s5_v_r || rdy6;
  assign in_ready = rdy5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else begin
      if (rdy5) s5_v_r <= in_valid;
      if (rdy6) s6_v_r <= s5_v_r;
    end
  end

  assign qa = in_data.mag_us[Q_W-1:QB_W];
  assign qb = in_data.mag_us[QB_W-1:0];

  assign square = (ACC_W'(s5_hh_r) << (2 * QB_W))
                + (ACC_W'(s5_hl_r) << (QB_W + 1))
                + ACC_W'(s5_ll_r);
  assign delta  = s5_neg_r ? (~ACC_W'(s5_q_r) + ACC_W'(1)) : ACC_W'(s5_q_r);

  always_ff @(posedge clk) begin
    if (in_valid && rdy5) begin
      s5_smp_r <= in_data.smp;
      s5_neg_r <= in_data.neg;
      s5_q_r   <= in_data.mag_us;
      s5_hh_r  <= (2*QA_W)'(qa) * (2*QA_W)'(qa);
      s5_hl_r  <= (QA_W+QB_W)'(qa) * (QA_W+QB_W)'(qb);
      s5_ll_r  <= (2*QB_W)'(qb) * (2*QB_W)'(qb);
    end
    if (s5_v_r && rdy6) begin
      s6_r.smp      <= s5_smp_r;
      s6_r.square   <= square;
      s6_r.delta_us <= delta;
    end
  end

  assign out_valid = s6_v_r;
  assign out_data  = s6_r;

endmodule

FILE: hdl/cps_accum.sv
// ---------------------------------------------------------------------------
// cps_accum
// Statistics state and result register: window tracking, extremes and the
// wrapping 64-bit accumulators. The state itself is the published snapshot.
// ---------------------------------------------------------------------------
module cps_accum (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cps_pkg::sq_t     in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output cps_pkg::stats_t  out_data
);
  import cps_pkg::*;

  stats_t stats_r, stats_nxt;
  logic   out_valid_r;
  logic   take;
  logic   new_win;

  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;
  assign new_win  = (in_data.smp.win_req != stats_r.window_number)
                 || (stats_r.sample_count == '0);

  always_comb begin
    stats_nxt = stats_r;
    if (take) begin
      if (new_win) begin
        stats_nxt.window_number       = in_data.smp.win_req;
        stats_nxt.window_min_period   = in_data.smp.cyc_period;
        stats_nxt.window_max_period   = in_data.smp.cyc_period;
        stats_nxt.window_max_lateness = in_data.smp.wake_late;
      end else begin
        if ($signed(in_data.smp.cyc_period) < $signed(stats_r.window_min_period))
          stats_nxt.window_min_period = in_data.smp.cyc_period;
        if ($signed(in_data.smp.cyc_period) > $signed(stats_r.window_max_period))
          stats_nxt.window_max_period = in_data.smp.cyc_period;
        if ($signed(in_data.smp.wake_late) > $signed(stats_r.window_max_lateness))
          stats_nxt.window_max_lateness = in_data.smp.wake_late;
      end
      stats_nxt.sample_count      = stats_r.sample_count + ACC_W'(1);
      stats_nxt.period_sum_us     = stats_r.period_sum_us + in_data.delta_us;
      stats_nxt.period_square_sum = stats_r.period_square_sum + in_data.square;
      stats_nxt.overrun_count     = stats_r.overrun_count
                                  + ACC_W'(in_data.smp.overrun_flag);
      stats_nxt.clamp_count       = stats_r.clamp_count
                                  + ACC_W'(in_data.smp.clamp_flag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stats_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      stats_r <= stats_nxt;
      if (in_ready) out_valid_r <= in_valid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = stats_r;

endmodule
